@@ hw/rtl/tri3d_pkg.sv @@
// ============================================================================
// tri3d_pkg: shared constants for the triangle area pipeline
// Port widths and the default coordinate width used across the block.
// ============================================================================
`default_nettype none

package tri3d_pkg;

  // Width of each vertex coordinate port
  localparam int FIELD_WIDTH = 16;

  // Width of the area result port
  localparam int AREA_OUT_WIDTH = 34;

  // Default number of coordinate bits taken from each field
  localparam int COORD_WIDTH_DEF = 16;

endpackage

`default_nettype wire

@@ hw/rtl/tri3d_cross.sv @@
// ============================================================================
// tri3d_cross: edge vectors and cross product magnitudes
// Three stages: edge differences, six products, component difference with
// absolute value.
// ============================================================================
`default_nettype none

module tri3d_cross #(
  parameter int COORD_WIDTH = tri3d_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]   a_x,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]   a_y,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]   a_z,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]   b_x,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]   b_y,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]   b_z,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]   c_x,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]   c_y,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]   c_z,
  output logic                                     out_valid,
  output logic [2*COORD_WIDTH:0]                   mag_x,
  output logic [2*COORD_WIDTH:0]                   mag_y,
  output logic [2*COORD_WIDTH:0]                   mag_z
);

  localparam int DW = COORD_WIDTH + 1;     // edge difference, signed
  localparam int PW = 2 * COORD_WIDTH + 2; // product and cross component, signed
  localparam int AW = 2 * COORD_WIDTH + 1; // cross component magnitude

  // Take the low coordinate bits as signed values
  logic signed [COORD_WIDTH-1:0] ax_c, ay_c, az_c, bx_c, by_c, bz_c, cx_c, cy_c, cz_c;

  assign ax_c = a_x[COORD_WIDTH-1:0];
  assign ay_c = a_y[COORD_WIDTH-1:0];
  assign az_c = a_z[COORD_WIDTH-1:0];
  assign bx_c = b_x[COORD_WIDTH-1:0];
  assign by_c = b_y[COORD_WIDTH-1:0];
  assign bz_c = b_z[COORD_WIDTH-1:0];
  assign cx_c = c_x[COORD_WIDTH-1:0];
  assign cy_c = c_y[COORD_WIDTH-1:0];
  assign cz_c = c_z[COORD_WIDTH-1:0];

  // Stage 1 registers: edge vectors AB and AC
  logic              vld1;
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;

  // Stage 2 registers: cross product terms
  logic              vld2;
  logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  // Stage 3 combinational: cross components
  logic signed [PW-1:0] cr_x, cr_y, cr_z;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  // Form the edge vectors from the first vertex
  always_ff @(posedge clk) begin
    ux <= DW'(bx_c) - DW'(ax_c);
    uy <= DW'(by_c) - DW'(ay_c);
    uz <= DW'(bz_c) - DW'(az_c);
    vx <= DW'(cx_c) - DW'(ax_c);
    vy <= DW'(cy_c) - DW'(ay_c);
    vz <= DW'(cz_c) - DW'(az_c);
  end

  // Multiply the edge components pairwise
  always_ff @(posedge clk) begin
    p_yz <= PW'(uy * vz);
    p_zy <= PW'(uz * vy);
    p_zx <= PW'(uz * vx);
    p_xz <= PW'(ux * vz);
    p_xy <= PW'(ux * vy);
    p_yx <= PW'(uy * vx);
  end

  // Subtract the terms; the true value always fits in PW bits
  assign cr_x = p_yz - p_zy;
  assign cr_y = p_zx - p_xz;
  assign cr_z = p_xy - p_yx;

  // Drop the sign: magnitude stays below 2^AW
  always_ff @(posedge clk) begin
    mag_x <= cr_x[PW-1] ? AW'(-cr_x) : AW'(cr_x);
    mag_y <= cr_y[PW-1] ? AW'(-cr_y) : AW'(cr_y);
    mag_z <= cr_z[PW-1] ? AW'(-cr_z) : AW'(cr_z);
  end

endmodule

`default_nettype wire

@@ hw/rtl/tri3d_sqsum.sv @@
// ============================================================================
// tri3d_sqsum: squared length of the cross product
// Three stages: split partial products, assemble each square, sum the three.
// ============================================================================
`default_nettype none

module tri3d_sqsum #(
  parameter int COORD_WIDTH = tri3d_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [2*COORD_WIDTH:0]     mag_x,
  input  wire logic [2*COORD_WIDTH:0]     mag_y,
  input  wire logic [2*COORD_WIDTH:0]     mag_z,
  output logic                            out_valid,
  output logic [4*COORD_WIDTH+3:0]        sum_sq
);

  localparam int AW  = 2 * COORD_WIDTH + 1; // magnitude width
  localparam int LW  = (AW + 1) / 2;        // low split
  localparam int HW  = AW - LW;             // high split
  localparam int SQW = 2 * AW;              // one square
  localparam int RW  = 4 * COORD_WIDTH + 4; // sum of three squares

  // Stage 4 registers: partial products
  logic             vld4;
  logic [2*HW-1:0]  hh_x, hh_y, hh_z;
  logic [HW+LW-1:0] hl_x, hl_y, hl_z;
  logic [2*LW-1:0]  ll_x, ll_y, ll_z;

  // Stage 5 registers: squares
  logic             vld5;
  logic [SQW-1:0]   sq_x, sq_y, sq_z;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld4      <= 1'b0;
      vld5      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld4      <= in_valid;
      vld5      <= vld4;
      out_valid <= vld5;
    end
  end

  // Split each magnitude into high and low halves and multiply
  always_ff @(posedge clk) begin
    hh_x <= mag_x[AW-1:LW] * mag_x[AW-1:LW];
    hh_y <= mag_y[AW-1:LW] * mag_y[AW-1:LW];
    hh_z <= mag_z[AW-1:LW] * mag_z[AW-1:LW];
    hl_x <= mag_x[AW-1:LW] * mag_x[LW-1:0];
    hl_y <= mag_y[AW-1:LW] * mag_y[LW-1:0];
    hl_z <= mag_z[AW-1:LW] * mag_z[LW-1:0];
    ll_x <= mag_x[LW-1:0] * mag_x[LW-1:0];
    ll_y <= mag_y[LW-1:0] * mag_y[LW-1:0];
    ll_z <= mag_z[LW-1:0] * mag_z[LW-1:0];
  end

  // Assemble the squares; the cross term counts twice
  always_ff @(posedge clk) begin
    sq_x <= (SQW'(hh_x) << (2 * LW)) + (SQW'(hl_x) << (LW + 1)) + SQW'(ll_x);
    sq_y <= (SQW'(hh_y) << (2 * LW)) + (SQW'(hl_y) << (LW + 1)) + SQW'(ll_y);
    sq_z <= (SQW'(hh_z) << (2 * LW)) + (SQW'(hl_z) << (LW + 1)) + SQW'(ll_z);
  end

  // Sum the three squares
  always_ff @(posedge clk) begin
    sum_sq <= RW'(sq_x) + RW'(sq_y) + RW'(sq_z);
  end

endmodule

`default_nettype wire

@@ hw/rtl/tri3d_sqrt.sv @@
// ============================================================================
// tri3d_sqrt: pipelined integer square root (floor)
// One result bit per stage, restoring digit-by-digit method.
// ============================================================================
`default_nettype none

module tri3d_sqrt #(
  parameter int COORD_WIDTH = tri3d_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [4*COORD_WIDTH+3:0]    radicand,
  output logic                             out_valid,
  output logic [2*COORD_WIDTH+1:0]         root
);

  localparam int NW   = 2 * COORD_WIDTH + 2; // root width, also stage count
  localparam int RW   = 2 * NW;              // radicand width
  localparam int REMW = NW + 3;              // partial remainder width

  // Stage registers, index k holds the state after k result bits
  logic            vld_q  [1:NW];
  logic [RW-1:0]   rad_q  [1:NW];
  logic [REMW-1:0] rem_q  [1:NW];
  logic [NW-1:0]   root_q [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic            vld_in;
    logic [RW-1:0]   rad_in;
    logic [REMW-1:0] rem_in;
    logic [NW-1:0]   root_in;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            take;

    // Pick the stage input
    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[k];
      assign rad_in  = rad_q[k];
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[REMW-3:0], rad_in[RW-1:RW-2]};
    assign trial  = REMW'({root_in, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rad_q[k+1]  <= rad_in << 2;
      rem_q[k+1]  <= take ? (rem_sh - trial) : rem_sh;
      root_q[k+1] <= {root_in[NW-2:0], take};
    end
  end

  assign out_valid = vld_q[NW];
  assign root      = root_q[NW];

  // A finished root leaves a remainder no larger than twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld_q[NW] |-> (rem_q[NW] <= {root_q[NW], 1'b0}))
    else $error("square root remainder out of range");

endmodule

`default_nettype wire

@@ hw/rtl/triangle_area_3d.sv @@
// ============================================================================
// triangle_area_3d: area of a 3-D mesh triangle with one fractional bit
// Cross product of the edge vectors followed by a pipelined square root.
// ============================================================================
// Takes one triangle per clock cycle: a transfer happens whenever start is
// high and busy is low, and busy is high only while reset is applied and in
// the cycle after reset. The result appears on area_half_units with done
// high for exactly one cycle; three stages form the cross product, three
// form its squared length, and the square root takes one stage per result
// bit. Results come back in order and cannot be held off, so capture them
// on the cycle that done is high.
`default_nettype none

module triangle_area_3d #(
  parameter int COORD_WIDTH = tri3d_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]     a_x,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]     a_y,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]     a_z,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]     b_x,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]     b_y,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]     b_z,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]     c_x,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]     c_y,
  input  wire logic [tri3d_pkg::FIELD_WIDTH-1:0]     c_z,
  output logic                                       done,
  output logic [tri3d_pkg::AREA_OUT_WIDTH-1:0]       area_half_units
);

  localparam int LAT = 2 * COORD_WIDTH + 8;

  logic                      in_xfer;
  logic                      cross_vld;
  logic [2*COORD_WIDTH:0]    mag_x, mag_y, mag_z;
  logic                      sum_vld;
  logic [4*COORD_WIDTH+3:0]  sum_sq;
  logic [2*COORD_WIDTH+1:0]  root;

  // Hold off transfers through reset and in the cycle after it
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign in_xfer = start & ~busy;

  tri3d_cross #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_xfer),
    .a_x       (a_x),
    .a_y       (a_y),
    .a_z       (a_z),
    .b_x       (b_x),
    .b_y       (b_y),
    .b_z       (b_z),
    .c_x       (c_x),
    .c_y       (c_y),
    .c_z       (c_z),
    .out_valid (cross_vld),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .mag_z     (mag_z)
  );

  tri3d_sqsum #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_sqsum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_vld),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .mag_z     (mag_z),
    .out_valid (sum_vld),
    .sum_sq    (sum_sq)
  );

  tri3d_sqrt #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_vld),
    .radicand  (sum_sq),
    .out_valid (done),
    .root      (root)
  );

  // Fit the root to the width of the result port
  assign area_half_units = tri3d_pkg::AREA_OUT_WIDTH'(root);

  // Every transfer yields exactly one result, and every result has a transfer
  a_xfer_to_done: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> ##LAT done)
    else $error("transfer produced no result");

  a_done_from_xfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_xfer, LAT))
    else $error("result without a matching transfer");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ============================================================================
// tb: self-checking bench for triangle_area_3d
// Streams vertex triples through the area pipeline with random start gaps and
// bursts, predicts floor(|AB x AC|) for every transfer, and checks each done
// strobe against the oldest prediction in order.
// ============================================================================
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W       = tri3d_pkg::COORD_WIDTH_DEF;
  localparam int PIPE_DEPTH    = 2 * COORD_W + 8;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int MAX_IDLE      = 13;

  typedef logic [tri3d_pkg::FIELD_WIDTH-1:0]    coord_bits_t;
  typedef logic [tri3d_pkg::AREA_OUT_WIDTH-1:0] area_t;

  // One triangle plus the start gap drawn for it
  typedef struct {
    coord_bits_t a_x, a_y, a_z;
    coord_bits_t b_x, b_y, b_z;
    coord_bits_t c_x, c_y, c_z;
    int          idle;
  } tri_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  coord_bits_t a_x = '0, a_y = '0, a_z = '0;
  coord_bits_t b_x = '0, b_y = '0, b_z = '0;
  coord_bits_t c_x = '0, c_y = '0, c_z = '0;
  logic        done;
  area_t       area_half_units;

  tri_item_t   pending_tris[$];
  area_t       area_due[$];
  int          mismatch_count = 0;
  bit          last_xfer = 1'b0;
  bit          holding = 1'b0;
  bit          gap_loaded = 1'b0;
  int          gap_left = 0;

  triangle_area_3d u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .a_x             (a_x),
    .a_y             (a_y),
    .a_z             (a_z),
    .b_x             (b_x),
    .b_y             (b_y),
    .b_z             (b_z),
    .c_x             (c_x),
    .c_y             (c_y),
    .c_z             (c_z),
    .done            (done),
    .area_half_units (area_half_units)
  );

  always #10 clk = ~clk;

  // Take the low COORD_W bits of a field and sign-extend them
  function automatic longint coord_of(coord_bits_t v);
    longint x;
    x = longint'(v) & ((longint'(1) << COORD_W) - 1);
    if (x[COORD_W-1]) x = x - (longint'(1) << COORD_W);
    return x;
  endfunction

  // Floor of the square root of a wide unsigned value, one result bit per pass
  function automatic area_t floor_sqrt(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = tri3d_pkg::AREA_OUT_WIDTH - 1; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    return r[tri3d_pkg::AREA_OUT_WIDTH-1:0];
  endfunction

  // Twice the triangle area: floor of the cross product length of AB and AC
  function automatic area_t tri_area_half(tri_item_t t);
    longint ax, ay, az, ux, uy, uz, vx, vy, vz;
    logic signed [127:0] kx, ky, kz;
    logic [127:0] len_sq;
    ax = coord_of(t.a_x);
    ay = coord_of(t.a_y);
    az = coord_of(t.a_z);
    ux = coord_of(t.b_x) - ax;
    uy = coord_of(t.b_y) - ay;
    uz = coord_of(t.b_z) - az;
    vx = coord_of(t.c_x) - ax;
    vy = coord_of(t.c_y) - ay;
    vz = coord_of(t.c_z) - az;
    kx = uy * vz - uz * vy;
    ky = uz * vx - ux * vz;
    kz = ux * vy - uy * vx;
    len_sq = kx * kx + ky * ky + kz * kz;
    return floor_sqrt(len_sq);
  endfunction

  function automatic void add_tri(int ax, int ay, int az, int bx, int by, int bz,
                                  int cx, int cy, int cz, int idle);
    tri_item_t t;
    t.a_x = coord_bits_t'(ax);
    t.a_y = coord_bits_t'(ay);
    t.a_z = coord_bits_t'(az);
    t.b_x = coord_bits_t'(bx);
    t.b_y = coord_bits_t'(by);
    t.b_z = coord_bits_t'(bz);
    t.c_x = coord_bits_t'(cx);
    t.c_y = coord_bits_t'(cy);
    t.c_z = coord_bits_t'(cz);
    t.idle = idle;
    pending_tris.push_back(t);
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  // Drive: present triangles after their gap, hold start until the transfer
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      holding = 1'b0;
      gap_loaded = 1'b0;
    end else begin
      if (holding && last_xfer) holding = 1'b0;
      if (!holding && pending_tris.size() > 0) begin
        if (!gap_loaded) begin
          gap_left = pending_tris[0].idle;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) gap_left--;
        else begin
          tri_item_t t;
          t = pending_tris.pop_front();
          a_x <= t.a_x; a_y <= t.a_y; a_z <= t.a_z;
          b_x <= t.b_x; b_y <= t.b_y; b_z <= t.b_z;
          c_x <= t.c_x; c_y <= t.c_y; c_z <= t.c_z;
          holding = 1'b1;
          gap_loaded = 1'b0;
        end
      end
      // Scramble the fields while idle; the block must ignore them
      if (!holding) begin
        a_x <= coord_bits_t'($urandom); a_y <= coord_bits_t'($urandom);
        a_z <= coord_bits_t'($urandom); b_x <= coord_bits_t'($urandom);
        b_y <= coord_bits_t'($urandom); b_z <= coord_bits_t'($urandom);
        c_x <= coord_bits_t'($urandom); c_y <= coord_bits_t'($urandom);
        c_z <= coord_bits_t'($urandom);
      end
      start <= holding;
    end
  end

  // Monitor: predict on each transfer, check each done strobe in order
  always @(posedge clk) begin
    tri_item_t seen;
    area_t     want;
    last_xfer = !rst && start && !busy;
    if (last_xfer) begin
      seen.a_x = a_x; seen.a_y = a_y; seen.a_z = a_z;
      seen.b_x = b_x; seen.b_y = b_y; seen.b_z = b_z;
      seen.c_x = c_x; seen.c_y = c_y; seen.c_z = c_z;
      seen.idle = 0;
      area_due.push_back(tri_area_half(seen));
    end
    if (!rst && done) begin
      if (area_due.size() == 0) begin
        $error("area_half_units: no result expected, got %0d", area_half_units);
        mismatch_count++;
      end else begin
        want = area_due.pop_front();
        if (area_half_units !== want) begin
          $error("area_half_units: expected %0d, got %0d", want, area_half_units);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int  p[9];
    int  idle;
    int  k;
    bit  burst;
    burst = 1'b0;

    // Directed: degenerate shapes, plane-aligned triangles, extremes
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 0);
    add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);
    add_tri(0, 0, 0, 0, 1, 0, 0, 0, 1, 3);
    add_tri(0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
    add_tri(1, 2, 3, 2, 4, 6, 3, 6, 9, 0);
    add_tri(-7, 3, 11, -7, 3, 11, 100, -200, 300, 1);
    add_tri(100, -200, 300, -50, 60, 70, 100, -200, 300, 0);
    add_tri(10, 20, 30, -40, 50, 60, -40, 50, 60, 0);
    add_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768, 0);
    add_tri(-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 0);
    add_tri(32767, 32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768, 5);
    add_tri(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767, 0);
    add_tri(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768, 0);
    add_tri(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0);
    add_tri(-1, -1, -1, 1, 1, 1, -1, 1, -1, 13);
    add_tri('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h0F0F, 'hF0F0, 'h00FF, 0);
    add_tri('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hF0F0, 'h0F0F, 'hFF00, 0);
    add_tri(-32767, 0, 32767, 0, -32767, 32767, 32767, -32767, 0, 0);
    add_tri(1, 1, 1, 1, 1, 2, 1, 2, 1, 2);

    // Random: full-range, with extreme, local, collinear and shared vertices
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      idle = burst ? 0 : $urandom_range(0, MAX_IDLE);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int i = 0; i < 9; i++) p[i] = $urandom;
        end
        4, 5: begin
          for (int i = 0; i < 9; i++) p[i] = pick_extreme();
        end
        6, 7: begin
          for (int i = 0; i < 3; i++) p[i] = $urandom_range(0, 60000) - 30000;
          for (int i = 3; i < 9; i++) p[i] = p[i % 3] + $urandom_range(0, 4095) - 2048;
        end
        8: begin
          k = $urandom_range(0, 2);
          for (int i = 0; i < 3; i++) begin
            p[i] = $urandom_range(0, 20000) - 10000;
            p[i + 3] = p[i] + $urandom_range(0, 10000) - 5000;
            p[i + 6] = p[i] + k * (p[i + 3] - p[i]);
          end
        end
        default: begin
          for (int i = 0; i < 9; i++) p[i] = $urandom;
          k = $urandom_range(0, 2);
          for (int i = 0; i < 3; i++) begin
            if (k == 0) p[i + 3] = p[i];
            else if (k == 1) p[i + 6] = p[i];
            else p[i + 6] = p[i + 3];
          end
        end
      endcase
      add_tri(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], idle);
    end

    // Hold reset, then release on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every triangle transferred, every area returned, then settle
    while (pending_tris.size() > 0 || holding) @(posedge clk);
    while (area_due.size() > 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("triangle_area_3d verification clean");
    end else begin
      $display("triangle_area_3d verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("triangle_area_3d verification failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/tri3d_pkg.sv
hw/rtl/tri3d_cross.sv
hw/rtl/tri3d_sqsum.sv
hw/rtl/tri3d_sqrt.sv
hw/rtl/triangle_area_3d.sv
bench/tb.sv
